FILE: hdl/oct_pkg.sv
`default_nettype none

package oct_pkg;

	localparam int SAMPLE_BITS    = 24;
	localparam int COEF_FRAC_BITS = 16;
	localparam int COEF_BITS      = COEF_FRAC_BITS + 2;
	// sum of four samples needs two extra bits
	localparam int OPD_BITS       = SAMPLE_BITS + 2;
	localparam int PROD_BITS      = OPD_BITS + COEF_BITS;
	localparam int ACC_BITS       = PROD_BITS + 2;
	localparam int RND_BITS       = ACC_BITS - COEF_FRAC_BITS;
	localparam int NUM_TERMS      = 3;
	localparam int NUM_LANES      = 4;

	typedef logic signed [COEF_BITS-1:0] coef_t;
	typedef logic signed [OPD_BITS-1:0]  opd_t;
	typedef logic signed [PROD_BITS-1:0] prod_t;
	typedef logic signed [ACC_BITS-1:0]  acc_t;
	typedef logic signed [RND_BITS-1:0]  rnd_t;
	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	// round(2^16 / sqrt(n)) and friends
	localparam coef_t K2    = 18'sd46341;
	localparam coef_t K2N   = -18'sd46341;
	localparam coef_t K3    = 18'sd37837;
	localparam coef_t K6    = 18'sd26755;
	localparam coef_t K6X2N = -18'sd53510;
	localparam coef_t KH    = 18'sd32768;
	localparam coef_t KONE  = 18'sd65536;

	localparam acc_t RND_HALF = acc_t'(2 ** (COEF_FRAC_BITS - 1));
	localparam rnd_t SAT_MAX  = rnd_t'(2 ** (SAMPLE_BITS - 1) - 1);
	localparam rnd_t SAT_MIN  = rnd_t'(-(2 ** (SAMPLE_BITS - 1)));

	localparam logic [1:0] REG_DIRECTION    = 2'd0;
	localparam logic [1:0] REG_CHANNEL_MODE = 2'd1;

	localparam logic       DIR_FWD     = 1'b0;
	localparam logic [1:0] MODE_THREE  = 2'd1;
	localparam logic [1:0] MODE_FOUR   = 2'd2;

	typedef enum logic [2:0] {
		OP_PASS,
		OP_FWD3,
		OP_INV3,
		OP_FWD4,
		OP_INV4
	} op_t;

	typedef struct packed {
		coef_t coef;
		opd_t  opd;
	} term_t;

	typedef term_t [NUM_TERMS-1:0] lane_terms_t;

endpackage

`default_nettype wire

FILE: hdl/oct_lane.sv
`default_nettype none

module oct_lane (
	input  wire logic                clk,
	input  wire oct_pkg::lane_terms_t terms,
	output oct_pkg::sample_t         res_s5
);
	import oct_pkg::*;

	prod_t prod_s3 [NUM_TERMS];
	rnd_t  rnd_s4;
	acc_t  acc;

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_TERMS; i++) begin
			prod_s3[i] <= terms[i].coef * terms[i].opd;
		end
	end

	// round half up, then floor via the part-select
	always_comb begin
		acc = RND_HALF;
		for (int i = 0; i < NUM_TERMS; i++) begin
			acc = acc + acc_t'(prod_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		rnd_s4 <= acc[ACC_BITS-1:COEF_FRAC_BITS];
	end

	always_ff @(posedge clk) begin
		if (rnd_s4 > SAT_MAX) begin
			res_s5 <= SAT_MAX[SAMPLE_BITS-1:0];
		end else if (rnd_s4 < SAT_MIN) begin
			res_s5 <= SAT_MIN[SAMPLE_BITS-1:0];
		end else begin
			res_s5 <= rnd_s4[SAMPLE_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/opponent_color_transform.sv
// opponent color transform, one pixel per clock
// an accepted start is registered in stage s1 and moves through s2, s3 and s4 to s5, where done is high
// throughput: one request per cycle, busy is always low; the five register stages
// (input, operand select, multiply, sum and round, saturate) each hold one pixel
// reset (arst_n low, asynchronous): pipeline valid bits clear, direction = forward,
// channel_mode = three channels; results are not held back, done pulses for one cycle
`default_nettype none

module opponent_color_transform (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [1:0]       cfg_data,
	input  wire oct_pkg::sample_t sample_0,
	input  wire oct_pkg::sample_t sample_1,
	input  wire oct_pkg::sample_t sample_2,
	input  wire oct_pkg::sample_t sample_3,
	output logic                  done,
	output oct_pkg::sample_t      out_0,
	output oct_pkg::sample_t      out_1,
	output oct_pkg::sample_t      out_2,
	output oct_pkg::sample_t      out_3
);
	import oct_pkg::*;

	logic       direction_q;
	logic [1:0] channel_mode_q;
	op_t        op_d;

	logic    valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	op_t     op_s1;
	sample_t smp_s1 [NUM_LANES];

	lane_terms_t terms_d  [NUM_LANES];
	lane_terms_t terms_s2 [NUM_LANES];
	sample_t     res_s5   [NUM_LANES];
	opd_t        e0, e1, e2, e3;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q    <= DIR_FWD;
			channel_mode_q <= MODE_THREE;
		end else if (cfg_we) begin
			if (cfg_index == REG_DIRECTION) begin
				direction_q <= cfg_data[0];
			end else if (cfg_index == REG_CHANNEL_MODE) begin
				channel_mode_q <= cfg_data;
			end
		end
	end

	always_comb begin
		case (channel_mode_q)
			MODE_THREE: op_d = (direction_q == DIR_FWD) ? OP_FWD3 : OP_INV3;
			MODE_FOUR:  op_d = (direction_q == DIR_FWD) ? OP_FWD4 : OP_INV4;
			default:    op_d = OP_PASS;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1     <= op_d;
			smp_s1[0] <= sample_0;
			smp_s1[1] <= sample_1;
			smp_s1[2] <= sample_2;
			smp_s1[3] <= sample_3;
		end
	end

	function automatic term_t mk(coef_t c, opd_t x);
		term_t t;
		t.coef = c;
		t.opd  = x;
		return t;
	endfunction

	assign e0 = opd_t'(smp_s1[0]);
	assign e1 = opd_t'(smp_s1[1]);
	assign e2 = opd_t'(smp_s1[2]);
	assign e3 = opd_t'(smp_s1[3]);

	// every output is up to three coefficient * operand terms; passthrough is 1.0 * sample
	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			terms_d[l] = '0;
		end
		case (op_s1)
			OP_FWD3: begin
				terms_d[0][0] = mk(K3, e0 + e1 + e2);
				terms_d[1][0] = mk(K2, e0 - e2);
				terms_d[2][0] = mk(K6, e0 + e2);
				terms_d[2][1] = mk(K6X2N, e1);
				terms_d[3][0] = mk(KONE, e3);
			end
			OP_INV3: begin
				terms_d[0][0] = mk(K3, e0);
				terms_d[0][1] = mk(K2, e1);
				terms_d[0][2] = mk(K6, e2);
				terms_d[1][0] = mk(K3, e0);
				terms_d[1][1] = mk(K6X2N, e2);
				terms_d[2][0] = mk(K3, e0);
				terms_d[2][1] = mk(K2N, e1);
				terms_d[2][2] = mk(K6, e2);
				terms_d[3][0] = mk(KONE, e3);
			end
			OP_FWD4: begin
				terms_d[0][0] = mk(KH, e0 + e1 + e2 + e3);
				terms_d[1][0] = mk(K2, e1 - e2);
				terms_d[2][0] = mk(KH, e1 + e2 - e0 - e3);
				terms_d[3][0] = mk(K2, e3 - e0);
			end
			OP_INV4: begin
				terms_d[0][0] = mk(KH, e0 - e2);
				terms_d[0][1] = mk(K2N, e3);
				terms_d[1][0] = mk(KH, e0 + e2);
				terms_d[1][1] = mk(K2, e1);
				terms_d[2][0] = mk(KH, e0 + e2);
				terms_d[2][1] = mk(K2N, e1);
				terms_d[3][0] = mk(KH, e0 - e2);
				terms_d[3][1] = mk(K2, e3);
			end
			default: begin
				terms_d[0][0] = mk(KONE, e0);
				terms_d[1][0] = mk(KONE, e1);
				terms_d[2][0] = mk(KONE, e2);
				terms_d[3][0] = mk(KONE, e3);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < NUM_LANES; l++) begin
			terms_s2[l] <= terms_d[l];
		end
	end

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		oct_lane u_lane (
			.clk    (clk),
			.terms  (terms_s2[g]),
			.res_s5 (res_s5[g])
		);
	end

	assign done  = valid_s5;
	assign out_0 = res_s5[0];
	assign out_1 = res_s5[1];
	assign out_2 = res_s5[2];
	assign out_3 = res_s5[3];

endmodule

`default_nettype wire
